[hw/rtl/assert_macros.svh]
// Assertion helpers used by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous active-low reset.
`define QTE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication under synchronous active-low reset.
`define QTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

[hw/rtl/qte_pkg.sv]
// ----------------------------------------------------------------------------
// qte_pkg
// Types, widths and the arctangent table of the quaternion to Euler block.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

    localparam int NUM_SENSORS_DEF  = 2;
    localparam int CORDIC_ITERS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;

    localparam int QW    = 16;  // quaternion component width
    localparam int DEG_W = 9;   // angle on the 0..359 scale
    localparam int CW    = 40;  // CORDIC x/y datapath
    localparam int AW    = 34;  // angle accumulator, 2^-32 turn units
    localparam int IW    = 5;   // CORDIC step index

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_PSQ,
        S_SQRT,
        S_CINIT,
        S_CITER,
        S_SCALE,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_POSE   = 2'd1,
        MODE_UNPAIR = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PASS_ROLL  = 2'd0,
        PASS_PITCH = 2'd1,
        PASS_YAW   = 2'd2
    } t_pass;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turns(input logic [IW-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/qte_cordic_step.sv]
// ----------------------------------------------------------------------------
// qte_cordic_step
// One vectoring micro-rotation, shared by the roll, pitch and yaw passes.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic_step (
    input  wire logic signed [qte_pkg::CW-1:0] i_x,
    input  wire logic signed [qte_pkg::CW-1:0] i_y,
    input  wire logic signed [qte_pkg::AW-1:0] i_z,
    input  wire logic        [qte_pkg::IW-1:0] i_idx,
    output logic      signed [qte_pkg::CW-1:0] o_x,
    output logic      signed [qte_pkg::CW-1:0] o_y,
    output logic      signed [qte_pkg::AW-1:0] o_z
);
    import qte_pkg::*;

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [AW-1:0] ang;

    // arithmetic shift is a floor shift
    assign xs  = i_x >>> i_idx;
    assign ys  = i_y >>> i_idx;
    assign ang = $signed({{(AW-32){1'b0}}, atan_turns(i_idx)});

    // rotate toward y = 0
    always_comb begin
        if (i_y >= 0) begin
            o_x = i_x + ys;
            o_y = i_y - xs;
            o_z = i_z + ang;
        end else begin
            o_x = i_x - ys;
            o_y = i_y + xs;
            o_z = i_z - ang;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/quaternion_to_euler_with_origin.sv]
// Sample path from accept to o_valid: the shared multiplier, the bit-serial square
//   root and the single CORDIC step unit reused for roll, pitch and yaw.
// No new item is accepted until the previous sample's result is loaded, and i_stall
//   holds the finished result. Pose and unpair items are taken while idle.
// Synchronous active-low reset clears the sequencer, output valid and origins.
`default_nettype none

`include "assert_macros.svh"

module quaternion_to_euler_with_origin #(
    parameter int NUM_SENSORS  = qte_pkg::NUM_SENSORS_DEF,
    parameter int CORDIC_ITERS = qte_pkg::CORDIC_ITERS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [1:0]                       i_mode,
    input  wire logic                             i_sensor_index,
    input  wire logic signed [qte_pkg::QW-1:0]    i_quat_w,
    input  wire logic signed [qte_pkg::QW-1:0]    i_quat_x,
    input  wire logic signed [qte_pkg::QW-1:0]    i_quat_y,
    input  wire logic signed [qte_pkg::QW-1:0]    i_quat_z,
    input  wire logic                             i_is_fist,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic                                  o_sensor_out,
    output logic [qte_pkg::DEG_W-1:0]             o_roll_deg,
    output logic [qte_pkg::DEG_W-1:0]             o_pitch_deg,
    output logic [qte_pkg::DEG_W-1:0]             o_yaw_deg,
    output logic [qte_pkg::DEG_W-1:0]             o_origin_roll_out,
    output logic [qte_pkg::DEG_W-1:0]             o_origin_pitch_out,
    output logic [qte_pkg::DEG_W-1:0]             o_origin_yaw_out
);
    import qte_pkg::*;

    localparam int SW  = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int NIT = (CORDIC_ITERS < ATAN_ENTRIES) ? CORDIC_ITERS : ATAN_ENTRIES;
    localparam int MW  = 30;   // multiplier operand width
    localparam int TW  = 36;   // product sums
    localparam int RW  = 58;   // square root remainder

    localparam logic [IW-1:0] MUL_LAST  = IW'(8);
    localparam logic [IW-1:0] SQRT_LAST = IW'(28);
    localparam logic [IW-1:0] CORD_LAST = IW'(NIT - 1);

    localparam logic signed [TW-1:0] ONE_Q28  = TW'(64'sd268435456);
    localparam logic signed [TW-1:0] NONE_Q28 = -ONE_Q28;
    localparam logic signed [AW-1:0] HALF_T   = AW'(64'sd2147483648);
    localparam logic signed [AW-1:0] QUART_T  = AW'(64'sd1073741824);

    t_state r_state, n_state;
    logic   [IW-1:0] r_cnt;
    t_pass  r_pass;

    logic signed [QW-1:0] r_w, r_x, r_y, r_z;
    logic                 r_sb;
    logic signed [TW-1:0] r_rn, r_rd, r_yn, r_yd, r_p;
    logic signed [MW-1:0] r_pc;
    logic        [RW-1:0] r_rem, r_root, r_bit;
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [AW-1:0] r_cz;
    logic [DEG_W-1:0]     r_roll, r_pitch, r_yaw;

    logic [DEG_W-1:0] r_org_roll  [NUM_SENSORS];
    logic [DEG_W-1:0] r_org_pitch [NUM_SENSORS];
    logic [DEG_W-1:0] r_org_yaw   [NUM_SENSORS];

    logic             r_ovalid;
    logic             r_osb;
    logic [DEG_W-1:0] r_oroll, r_opitch, r_oyaw, r_oor, r_oop, r_ooy;

    logic in_acc, load;
    logic [SW-1:0] in_idx, cur_idx;

    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign load    = (r_state == S_DONE) && (!r_ovalid || !i_stall);
    assign in_idx  = (NUM_SENSORS > 1) ? SW'(i_sensor_index) : '0;
    assign cur_idx = SW'(r_sb);

    // shared multiplier
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [2*MW-1:0] mul_p;
    logic signed [TW-1:0]   prod;

    always_comb begin
        mul_a = r_pc;
        mul_b = r_pc;
        case (r_cnt)
            5'd0: begin mul_a = MW'(r_w); mul_b = MW'(r_x); end
            5'd1: begin mul_a = MW'(r_y); mul_b = MW'(r_z); end
            5'd2: begin mul_a = MW'(r_x); mul_b = MW'(r_x); end
            5'd3: begin mul_a = MW'(r_y); mul_b = MW'(r_y); end
            5'd4: begin mul_a = MW'(r_z); mul_b = MW'(r_z); end
            5'd5: begin mul_a = MW'(r_w); mul_b = MW'(r_z); end
            5'd6: begin mul_a = MW'(r_x); mul_b = MW'(r_y); end
            5'd7: begin mul_a = MW'(r_w); mul_b = MW'(r_y); end
            5'd8: begin mul_a = MW'(r_z); mul_b = MW'(r_x); end
            default: begin mul_a = r_pc; mul_b = r_pc; end
        endcase
        if (r_state == S_PSQ) begin
            mul_a = r_pc;
            mul_b = r_pc;
        end
    end

    assign mul_p = mul_a * mul_b;
    assign prod  = TW'(mul_p);

    // doubled and clamped pitch argument
    logic signed [TW-1:0] p2, p2c;
    always_comb begin
        p2 = r_p <<< 1;
        if (p2 > ONE_Q28)
            p2c = ONE_Q28;
        else if (p2 < NONE_Q28)
            p2c = NONE_Q28;
        else
            p2c = p2;
    end

    // square root step
    logic [RW-1:0] sq_try;
    assign sq_try = r_root + r_bit;

    // CORDIC pass operands
    logic signed [TW-1:0] c_n, c_d;
    always_comb begin
        case (r_pass)
            PASS_ROLL:  begin c_n = r_rn;     c_d = r_rd; end
            PASS_PITCH: begin c_n = TW'(r_pc); c_d = $signed({1'b0, r_root[TW-2:0]}); end
            PASS_YAW:   begin c_n = r_yn;     c_d = r_yd; end
            default:    begin c_n = r_rn;     c_d = r_rd; end
        endcase
    end

    logic signed [CW-1:0] st_x, st_y;
    logic signed [AW-1:0] st_z;

    qte_cordic_step u_step (
        .i_x   (r_cx),
        .i_y   (r_cy),
        .i_z   (r_cz),
        .i_idx (r_cnt),
        .o_x   (st_x),
        .o_y   (st_y),
        .o_z   (st_z)
    );

    // angle to 0..359 scale
    logic signed [AW-1:0] zf, zh;
    logic        [AW-1:0] uf, uh;
    logic        [AW+9:0] tf, th;
    logic        [DEG_W-1:0] deg;
    always_comb begin
        zf = (r_cz > HALF_T) ? HALF_T : ((r_cz < -HALF_T) ? -HALF_T : r_cz);
        zh = (r_cz > QUART_T) ? QUART_T : ((r_cz < -QUART_T) ? -QUART_T : r_cz);
        uf = AW'(zf + HALF_T);
        uh = AW'(zh + QUART_T);
        tf = (AW+10)'(uf) * (AW+10)'(359);
        th = (AW+10)'(uh) * (AW+10)'(718);
        if (r_pass == PASS_PITCH)
            deg = (th[AW+9:32] > (AW-22)'(359)) ? DEG_W'(359) : DEG_W'(th[AW+9:32]);
        else
            deg = (tf[AW+9:32] > (AW-22)'(359)) ? DEG_W'(359) : DEG_W'(tf[AW+9:32]);
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc && (i_mode == MODE_SAMPLE)) n_state = S_MUL;
            S_MUL:   if (r_cnt == MUL_LAST) n_state = S_PREP;
            S_PREP:  n_state = S_PSQ;
            S_PSQ:   n_state = S_SQRT;
            S_SQRT:  if (r_cnt == SQRT_LAST) n_state = S_CINIT;
            S_CINIT: n_state = S_CITER;
            S_CITER: if (r_cnt == CORD_LAST) n_state = S_SCALE;
            S_SCALE: n_state = (r_pass == PASS_YAW) ? S_DONE : S_CINIT;
            S_DONE:  if (load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cnt  <= '0;
                r_pass <= PASS_ROLL;
                if (in_acc) begin
                    r_w  <= i_quat_w;
                    r_x  <= i_quat_x;
                    r_y  <= i_quat_y;
                    r_z  <= i_quat_z;
                    r_sb <= (NUM_SENSORS > 1) ? i_sensor_index : 1'b0;
                end
            end
            S_MUL: begin
                r_cnt <= (r_cnt == MUL_LAST) ? '0 : r_cnt + 1'b1;
                case (r_cnt)
                    5'd0: r_rn <= prod;
                    5'd1: r_rn <= r_rn + prod;
                    5'd2: r_rd <= prod;
                    5'd3: begin r_rd <= r_rd + prod; r_yd <= prod; end
                    5'd4: r_yd <= r_yd + prod;
                    5'd5: r_yn <= prod;
                    5'd6: r_yn <= r_yn + prod;
                    5'd7: r_p  <= prod;
                    5'd8: r_p  <= r_p - prod;
                    default: r_p <= r_p;
                endcase
            end
            S_PREP: begin
                r_rn <= r_rn <<< 1;
                r_rd <= ONE_Q28 - (r_rd <<< 1);
                r_yn <= r_yn <<< 1;
                r_yd <= ONE_Q28 - (r_yd <<< 1);
                r_pc <= MW'(p2c);
            end
            S_PSQ: begin
                r_rem  <= (RW'(1) << 56) - RW'(mul_p);
                r_root <= '0;
                r_bit  <= RW'(1) << 56;
                r_cnt  <= '0;
            end
            S_SQRT: begin
                r_cnt <= (r_cnt == SQRT_LAST) ? '0 : r_cnt + 1'b1;
                r_bit <= r_bit >> 2;
                if (r_rem >= sq_try) begin
                    r_rem  <= r_rem - sq_try;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
            end
            S_CINIT: begin
                r_cnt <= '0;
                if (c_d < 0) begin
                    r_cz <= (c_n >= 0) ? HALF_T : -HALF_T;
                    r_cx <= -CW'(c_d);
                    r_cy <= -CW'(c_n);
                end else begin
                    r_cz <= '0;
                    r_cx <= CW'(c_d);
                    r_cy <= CW'(c_n);
                end
            end
            S_CITER: begin
                r_cnt <= r_cnt + 1'b1;
                r_cx  <= st_x;
                r_cy  <= st_y;
                r_cz  <= st_z;
            end
            S_SCALE: begin
                case (r_pass)
                    PASS_ROLL:  begin r_roll  <= deg; r_pass <= PASS_PITCH; end
                    PASS_PITCH: begin r_pitch <= deg; r_pass <= PASS_YAW;   end
                    default:    begin r_yaw   <= deg; r_pass <= PASS_ROLL;  end
                endcase
            end
            default: r_cnt <= '0;
        endcase
    end

    // origins: cleared by unpair and fist pose items, set on load while unset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SENSORS; k++) begin
                r_org_roll[k]  <= '0;
                r_org_pitch[k] <= '0;
                r_org_yaw[k]   <= '0;
            end
        end else if (in_acc && (i_mode == MODE_UNPAIR)) begin
            for (int k = 0; k < NUM_SENSORS; k++) begin
                r_org_roll[k]  <= '0;
                r_org_pitch[k] <= '0;
                r_org_yaw[k]   <= '0;
            end
        end else if (in_acc && (i_mode == MODE_POSE) && i_is_fist) begin
            r_org_roll[in_idx]  <= '0;
            r_org_pitch[in_idx] <= '0;
            r_org_yaw[in_idx]   <= '0;
        end else if (load && (r_org_pitch[cur_idx] == '0)) begin
            r_org_roll[cur_idx]  <= r_roll;
            r_org_pitch[cur_idx] <= r_pitch;
            r_org_yaw[cur_idx]   <= r_yaw;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_ovalid <= 1'b0;
        else if (load)
            r_ovalid <= 1'b1;
        else if (!i_stall)
            r_ovalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_osb    <= r_sb;
            r_oroll  <= r_roll;
            r_opitch <= r_pitch;
            r_oyaw   <= r_yaw;
            if (r_org_pitch[cur_idx] == '0) begin
                r_oor <= r_roll;
                r_oop <= r_pitch;
                r_ooy <= r_yaw;
            end else begin
                r_oor <= r_org_roll[cur_idx];
                r_oop <= r_org_pitch[cur_idx];
                r_ooy <= r_org_yaw[cur_idx];
            end
        end
    end

    assign o_valid            = r_ovalid;
    assign o_sensor_out       = r_osb;
    assign o_roll_deg         = r_oroll;
    assign o_pitch_deg        = r_opitch;
    assign o_yaw_deg          = r_oyaw;
    assign o_origin_roll_out  = r_oor;
    assign o_origin_pitch_out = r_oop;
    assign o_origin_yaw_out   = r_ooy;

    // checks
    `QTE_ASSERT_NEXT(a_sample_starts, i_clk, i_rst_n,
        in_acc && (i_mode == MODE_SAMPLE), r_state == S_MUL)
    `QTE_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, load, r_ovalid)
    `QTE_ASSERT_NEXT(a_capture_origin, i_clk, i_rst_n,
        load && (r_org_pitch[cur_idx] == '0), o_origin_roll_out == o_roll_deg)
    `QTE_ASSERT_NOW(a_busy_no_accept, i_clk, i_rst_n,
        r_state != S_IDLE, !in_acc)

endmodule

`default_nettype wire
